/* rtl/svalloc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package svalloc_pkg;

	// Result limit per item
	localparam int MaxResults = 16;
	localparam int CntW       = 5;

	// Priority bonus for a releasing voice
	localparam logic [32:0] ReleaseBonus = 33'h0_007F_FFFF;

	// Item kinds
	localparam logic [2:0] KIND_NOTE_ON    = 3'd0;
	localparam logic [2:0] KIND_NOTE_OFF   = 3'd1;
	localparam logic [2:0] KIND_TICK       = 3'd2;
	localparam logic [2:0] KIND_VOICE_DONE = 3'd3;
	localparam logic [2:0] KIND_ABORT_ALL  = 3'd4;
	localparam logic [2:0] KIND_WRITE_ZONE = 3'd5;

	// Result actions
	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_START   = 2'd1;
	localparam logic [1:0] ACT_RELEASE = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_ACTIVE_VOICES = 2'd0;
	localparam logic [1:0] CFG_LOCKED        = 2'd1;
	localparam logic [1:0] CFG_ZONE_COUNT    = 2'd2;

	// Zone table entry (validity lives in flops)
	typedef struct packed {
		logic [6:0] low_key;
		logic [6:0] high_key;
		logic [6:0] low_vel;
		logic [6:0] high_vel;
	} zone_t;

	typedef enum logic {
		ALU_PRIO,
		ALU_AGE
	} alu_op_t;

	typedef struct packed {
		alu_op_t     op;
		logic [31:0] age;
		logic        zeroed;
		logic        releasing;
		logic [32:0] best;
	} alu_req_t;

	typedef struct packed {
		logic [32:0] prio;
		logic        gt;
		logic [31:0] aged;
	} alu_rsp_t;

	typedef struct packed {
		logic [1:0] action;
		logic [3:0] voice;
		logic [3:0] zone;
		logic [6:0] note_key;
		logic [6:0] note_velocity;
	} res_t;

endpackage

`default_nettype wire

/* rtl/svalloc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module svalloc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/svalloc_alu.sv */
`timescale 1ns / 1ps
`default_nettype none

module svalloc_alu
	import svalloc_pkg::*;
(
	input  wire alu_req_t req,
	output alu_rsp_t      rsp
);

	logic [31:0] base;
	logic [32:0] addend;
	logic [32:0] sum;

	// Shared adder: steal priority or saturating age increment
	always_comb begin
		base = req.zeroed ? 32'd0 : req.age;
		unique case (req.op)
			ALU_PRIO: addend = req.releasing ? ReleaseBonus : 33'd0;
			ALU_AGE:  addend = 33'd1;
			default:  addend = 33'd0;
		endcase
		sum      = {1'b0, base} + addend;
		rsp.prio = sum;
		rsp.gt   = (sum > req.best);
		rsp.aged = (base == 32'hFFFF_FFFF) ? base : sum[31:0];
	end

endmodule

`default_nettype wire

/* rtl/sampler_voice_allocator.sv */
// Steps: a tick walks all VOICES voices; a note-off walks the active voices; voice_done,
//   abort_all and write_zone finish on acceptance; a note-on scans the zones, runs a steal
//   sweep over the nv effective active voices when none is free, then starts the chosen voice.
// Throughput: one item at a time; voices and zones are walked one entry at a time
//   through the RAMs and shared adder; a result held by out_stall stalls the sequencer.
// Reset (async, active low) frees all voices, drops held keys, invalidates all zones.
`timescale 1ns / 1ps
`default_nettype none

module sampler_voice_allocator
	import svalloc_pkg::*;
#(
	parameter int VOICES = 16,
	parameter int ZONES  = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// input items
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] kind,
	input  wire logic [6:0] key,
	input  wire logic [6:0] velocity,
	input  wire logic [3:0] voice_index,
	input  wire logic [3:0] zone_index,
	input  wire logic [6:0] zone_low_key,
	input  wire logic [6:0] zone_high_key,
	input  wire logic [6:0] zone_low_velocity,
	input  wire logic [6:0] zone_high_velocity,
	input  wire logic       zone_valid,
	// result items
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      action,
	output logic [3:0]      voice,
	output logic [3:0]      zone,
	output logic [6:0]      note_key,
	output logic [6:0]      note_velocity,
	output logic            last,
	// configuration writes
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [4:0] cfg_data
);

	localparam int VW  = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CW  = $clog2(VOICES + 1);
	localparam int ZW  = (ZONES > 1) ? $clog2(ZONES) : 1;
	localparam int ZCW = $clog2(ZONES + 1);
	localparam int ZBITS = $bits(zone_t);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ZRD,
		S_ZEV,
		S_SRD,
		S_SEV,
		S_START,
		S_KRD,
		S_KEV,
		S_TRD,
		S_TEV,
		S_FIN
	} state_t;

	state_t state_q;

	// configuration
	logic [4:0] av_q;
	logic       locked_q;
	logic [4:0] zc_q;

	// per-voice and per-zone flags
	logic [VOICES-1:0] busy_q;
	logic [VOICES-1:0] rel_q;
	logic [VOICES-1:0] azero_q;
	logic [VOICES-1:0] hkv_q;
	logic [ZONES-1:0]  zvalid_q;

	// item and sweep registers
	logic [6:0]      key_q;
	logic [6:0]      vel_q;
	logic [CW-1:0]   vi_q;
	logic [ZCW-1:0]  zrem_q;
	logic [ZW-1:0]   zi_q;
	logic [VW-1:0]   chosen_q;
	logic [32:0]     best_q;
	logic            found_q;
	logic [CntW-1:0] cnt_q;

	// pending and output results
	res_t pend_q;
	logic pend_valid_q;
	res_t out_q;
	logic out_valid_q;
	logic out_last_q;

	// combinational
	logic [CW-1:0]  nv;
	logic [ZCW-1:0] nz;
	logic [CW-1:0]  cfg_nv;
	logic [VW-1:0]  vidx;
	logic           accept;
	logic           out_free;
	logic           cnt_full;
	logic           free_found;
	logic [VW-1:0]  free_idx;
	logic           zone_hit;
	logic           key_hit;
	logic           emit_req;
	logic           emit_go;
	res_t           emit_res;
	zone_t          zone_rd;
	logic [ZBITS-1:0] zram_rdata;
	logic [6:0]     kram_rdata;
	logic [31:0]    aram_rdata;
	logic           zram_we;
	logic           zram_re;
	logic           kram_we;
	logic           kram_re;
	logic           aram_we;
	logic           aram_re;
	alu_req_t       alu_req;
	alu_rsp_t       alu_rsp;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = (state_q == S_IDLE) && in_valid;
	assign out_free  = !out_valid_q || !out_stall;
	assign cnt_full  = (cnt_q == CntW'(MaxResults));
	assign vidx      = VW'(vi_q);

	assign nv     = (int'(av_q) < VOICES) ? CW'(av_q) : CW'(VOICES);
	assign nz     = (int'(zc_q) < ZONES) ? ZCW'(zc_q) : ZCW'(ZONES);
	assign cfg_nv = (int'(cfg_data) < VOICES) ? CW'(cfg_data) : CW'(VOICES);

	assign out_valid     = out_valid_q;
	assign action        = out_q.action;
	assign voice         = out_q.voice;
	assign zone          = out_q.zone;
	assign note_key      = out_q.note_key;
	assign note_velocity = out_q.note_velocity;
	assign last          = out_last_q;

	// lowest free voice among the active ones
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = VOICES - 1; i >= 0; i--) begin
			if (!busy_q[i] && (i < int'(nv))) begin
				free_found = 1'b1;
				free_idx   = VW'(i);
			end
		end
	end

	// zone and held-key match
	assign zone_rd  = zone_t'(zram_rdata);
	assign zone_hit = zvalid_q[zi_q]
		&& (key_q >= zone_rd.low_key) && (key_q <= zone_rd.high_key)
		&& (vel_q >= zone_rd.low_vel) && (vel_q <= zone_rd.high_vel);
	assign key_hit  = hkv_q[vidx] && (kram_rdata == key_q);

	// result to be produced this cycle
	always_comb begin
		emit_req = 1'b0;
		emit_res = '{ACT_NONE, 4'd0, 4'd0, 7'd0, 7'd0};
		if (state_q == S_START) begin
			emit_req = 1'b1;
			emit_res = '{ACT_START, 4'(chosen_q), 4'(zi_q), key_q, vel_q};
		end else if ((state_q == S_KEV) && key_hit && busy_q[vidx]) begin
			emit_req = 1'b1;
			emit_res = '{ACT_RELEASE, 4'(vidx), 4'd0, key_q, 7'd0};
		end
	end
	assign emit_go = emit_req && (!pend_valid_q || out_free);

	// memory controls
	assign zram_we = accept && (kind == KIND_WRITE_ZONE) && (int'(zone_index) < ZONES);
	assign zram_re = (state_q == S_ZRD) && (zrem_q != '0) && !cnt_full;
	assign kram_we = (state_q == S_START) && emit_go;
	assign kram_re = (state_q == S_KRD) && (vi_q != nv) && !cnt_full;
	assign aram_re = ((state_q == S_SRD) && (vi_q != nv))
		|| ((state_q == S_TRD) && (vi_q != CW'(VOICES)));
	assign aram_we = (state_q == S_TEV) && busy_q[vidx];

	// shared adder/compare unit
	always_comb begin
		alu_req.op        = (state_q == S_TEV) ? ALU_AGE : ALU_PRIO;
		alu_req.age       = aram_rdata;
		alu_req.zeroed    = azero_q[vidx];
		alu_req.releasing = rel_q[vidx];
		alu_req.best      = best_q;
	end

	svalloc_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	svalloc_ram #(.WIDTH(ZBITS), .DEPTH(ZONES)) u_zone_ram (
		.clk   (clk),
		.we    (zram_we),
		.waddr (ZW'(zone_index)),
		.wdata ({zone_low_key, zone_high_key, zone_low_velocity, zone_high_velocity}),
		.re    (zram_re),
		.raddr (ZW'(zrem_q - ZCW'(1))),
		.rdata (zram_rdata)
	);

	svalloc_ram #(.WIDTH(7), .DEPTH(VOICES)) u_key_ram (
		.clk   (clk),
		.we    (kram_we),
		.waddr (chosen_q),
		.wdata (key_q),
		.re    (kram_re),
		.raddr (vidx),
		.rdata (kram_rdata)
	);

	svalloc_ram #(.WIDTH(32), .DEPTH(VOICES)) u_age_ram (
		.clk   (clk),
		.we    (aram_we),
		.waddr (vidx),
		.wdata (alu_rsp.aged),
		.re    (aram_re),
		.raddr (vidx),
		.rdata (aram_rdata)
	);

	// sequencer, flags and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			av_q         <= 5'd16;
			locked_q     <= 1'b0;
			zc_q         <= 5'd0;
			busy_q       <= '0;
			rel_q        <= '0;
			azero_q      <= '1;
			hkv_q        <= '0;
			zvalid_q     <= '0;
			key_q        <= '0;
			vel_q        <= '0;
			vi_q         <= '0;
			zrem_q       <= '0;
			zi_q         <= '0;
			chosen_q     <= '0;
			best_q       <= '0;
			found_q      <= 1'b0;
			cnt_q        <= '0;
			pend_q       <= '{ACT_NONE, 4'd0, 4'd0, 7'd0, 7'd0};
			pend_valid_q <= 1'b0;
			out_q        <= '{ACT_NONE, 4'd0, 4'd0, 7'd0, 7'd0};
			out_valid_q  <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_ACTIVE_VOICES: begin
						av_q <= cfg_data;
						for (int i = 0; i < VOICES; i++) begin
							if (i >= int'(cfg_nv)) begin
								busy_q[i]  <= 1'b0;
								rel_q[i]   <= 1'b0;
								azero_q[i] <= 1'b1;
							end
						end
					end
					CFG_LOCKED:     locked_q <= cfg_data[0];
					CFG_ZONE_COUNT: zc_q <= cfg_data;
					default: ;
				endcase
			end

			// output register drains
			if (out_free) begin
				out_valid_q <= 1'b0;
			end

			// new result: pending one moves out, new one waits for its last flag
			if (emit_go) begin
				if (pend_valid_q) begin
					out_q       <= pend_q;
					out_last_q  <= 1'b0;
					out_valid_q <= 1'b1;
				end
				pend_q       <= emit_res;
				pend_valid_q <= 1'b1;
				cnt_q        <= cnt_q + CntW'(1);
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q <= key;
						vel_q <= velocity;
						vi_q  <= '0;
						cnt_q <= '0;
						unique case (kind)
							KIND_NOTE_ON: begin
								zrem_q <= nz;
								if (!locked_q) state_q <= S_ZRD;
							end
							KIND_NOTE_OFF: begin
								if (!locked_q) state_q <= S_KRD;
							end
							KIND_TICK: state_q <= S_TRD;
							KIND_VOICE_DONE: begin
								if (int'(voice_index) < VOICES) begin
									busy_q[VW'(voice_index)]  <= 1'b0;
									rel_q[VW'(voice_index)]   <= 1'b0;
									azero_q[VW'(voice_index)] <= 1'b1;
								end
							end
							KIND_ABORT_ALL: begin
								busy_q  <= '0;
								rel_q   <= '0;
								azero_q <= '1;
							end
							KIND_WRITE_ZONE: begin
								if (int'(zone_index) < ZONES) begin
									zvalid_q[ZW'(zone_index)] <= zone_valid;
								end
							end
							default: ;
						endcase
					end
				end

				// zone scan, highest entry first
				S_ZRD: begin
					if ((zrem_q == '0) || cnt_full) begin
						state_q <= S_FIN;
					end else begin
						zi_q    <= ZW'(zrem_q - ZCW'(1));
						zrem_q  <= zrem_q - ZCW'(1);
						state_q <= S_ZEV;
					end
				end
				S_ZEV: begin
					if (!zone_hit) begin
						state_q <= S_ZRD;
					end else if (free_found) begin
						chosen_q <= free_idx;
						state_q  <= S_START;
					end else begin
						vi_q    <= '0;
						best_q  <= '0;
						found_q <= 1'b0;
						state_q <= S_SRD;
					end
				end

				// steal sweep over active voices
				S_SRD: begin
					if (vi_q == nv) begin
						state_q <= found_q ? S_START : S_ZRD;
					end else begin
						state_q <= S_SEV;
					end
				end
				S_SEV: begin
					if (alu_rsp.gt) begin
						best_q   <= alu_rsp.prio;
						chosen_q <= vidx;
						found_q  <= 1'b1;
					end
					vi_q    <= vi_q + CW'(1);
					state_q <= S_SRD;
				end

				S_START: begin
					if (emit_go) begin
						busy_q[chosen_q]  <= 1'b1;
						rel_q[chosen_q]   <= 1'b0;
						azero_q[chosen_q] <= 1'b1;
						hkv_q[chosen_q]   <= 1'b1;
						found_q           <= 1'b0;
						state_q           <= S_ZRD;
					end
				end

				// note-off sweep
				S_KRD: begin
					if ((vi_q == nv) || cnt_full) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_KEV;
					end
				end
				S_KEV: begin
					if (!key_hit) begin
						vi_q    <= vi_q + CW'(1);
						state_q <= S_KRD;
					end else if (!busy_q[vidx]) begin
						hkv_q[vidx] <= 1'b0;
						vi_q        <= vi_q + CW'(1);
						state_q     <= S_KRD;
					end else if (emit_go) begin
						hkv_q[vidx] <= 1'b0;
						rel_q[vidx] <= 1'b1;
						vi_q        <= vi_q + CW'(1);
						state_q     <= S_KRD;
					end
				end

				// tick: age every busy voice
				S_TRD: begin
					state_q <= (vi_q == CW'(VOICES)) ? S_IDLE : S_TEV;
				end
				S_TEV: begin
					if (busy_q[vidx]) begin
						azero_q[vidx] <= 1'b0;
					end
					vi_q    <= vi_q + CW'(1);
					state_q <= S_TRD;
				end

				// flush the final result with its last flag
				S_FIN: begin
					if (!pend_valid_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_q        <= pend_q;
						out_last_q   <= 1'b1;
						out_valid_q  <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	// no result is left pending once the block is idle
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_valid_q)
		else $error("pending result left behind in idle");

	// result count stays within the limit
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(MaxResults))
		else $error("result count above limit");

	// a started voice is busy afterwards
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_START) && emit_go) |=> busy_q[$past(chosen_q)])
		else $error("started voice not marked busy");

	// a steal candidate always has a nonzero priority
	a_steal_prio: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (best_q != '0))
		else $error("steal candidate with zero priority");

endmodule

`default_nettype wire
